// ----- src/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and color helpers for the star field backdrop.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int unsigned LFSR_W      = 17;
    localparam int unsigned STORE_AW    = 16;
    localparam int unsigned ENTRY_W     = 7;
    localparam int unsigned RGB_W       = 24;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [LFSR_W-1:0] LFSR_PERIOD    = 17'd131071;
    localparam logic [LFSR_W-1:0] STAR_EN_MASK   = 17'h1fe01;
    localparam logic [LFSR_W-1:0] STAR_EN_MATCH  = 17'h1fe00;

    localparam logic [CFG_IDX_W-1:0] REG_BOARD_KIND       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STARS_ON         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_HORIZONTAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIVER_COLOR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RIVER_COLUMN     = 3'd6;

    localparam logic [1:0] BOARD_STAR_A = 2'd0;
    localparam logic [1:0] BOARD_STAR_B = 2'd1;
    localparam logic [1:0] BOARD_RIVER  = 2'd2;

    localparam logic [1:0] BLINK_TOP    = 2'd0;
    localparam logic [1:0] BLINK_MID    = 2'd1;
    localparam logic [1:0] BLINK_LINES  = 2'd2;
    localparam logic [1:0] BLINK_FIXED  = 2'd3;

    localparam logic [7:0] RIVER_COLUMN_RESET = 8'd128;

    typedef struct packed {
        logic [1:0]            board_kind;
        logic                  stars_on;
        logic                  background_on;
        logic                  flip_horizontal;
        logic [RGB_W-1:0]      background_color;
        logic [RGB_W-1:0]      river_color;
        logic [7:0]            river_column;
    } t_cfg;

    function automatic logic [7:0] gun_level(input logic [1:0] idx);
        logic [7:0] lvl;
        case (idx)
            2'd0:    lvl = 8'h00;
            2'd1:    lvl = 8'h66;
            2'd2:    lvl = 8'h99;
            default: lvl = 8'hff;
        endcase
        return lvl;
    endfunction

    function automatic logic [RGB_W-1:0] colour_to_rgb(input logic [5:0] col);
        return {gun_level({col[4], col[5]}),
                gun_level({col[2], col[3]}),
                gun_level({col[0], col[1]})};
    endfunction

endpackage

// ----- src/sfb_ram.sv -----
// ----------------------------------------------------------------------------
// sfb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfb_ram #(
    parameter int unsigned WIDTH = 7,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/star_field_backdrop_top.sv -----
// ----------------------------------------------------------------------------
// star_field_backdrop_top
// Per-pixel backdrop color: river split, configurable background or LFSR star field.
//
//   channel   dir  handshake                        payload
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready   x, y, blink phase
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready   rgb
//   cfg       in   i_cfg_we                         index, data
//
// One pixel per cycle unless the output stalls. After reset the fill
// sequencer walks the 17-bit LFSR one step per cycle over its full period,
// writing the star RAM on even steps; o_s_axis_tready stays low until it
// ends. Config writes are taken at any time. Each stage holds while the
// stage after it is full and stalled; bubbles still close up.
// ----------------------------------------------------------------------------
module star_field_backdrop_top
    import sfb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // pixel_x[7:0], pixel_y[15:8], blink_phase[17:16]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [23:0]           o_m_axis_tdata,  // rgb[23:0]
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.board_kind       <= BOARD_STAR_A;
            r_cfg.stars_on         <= 1'b0;
            r_cfg.background_on    <= 1'b0;
            r_cfg.flip_horizontal  <= 1'b0;
            r_cfg.background_color <= '0;
            r_cfg.river_color      <= '0;
            r_cfg.river_column     <= RIVER_COLUMN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BOARD_KIND:       r_cfg.board_kind       <= i_cfg_data[1:0];
                REG_STARS_ON:         r_cfg.stars_on         <= i_cfg_data[0];
                REG_BACKGROUND_ON:    r_cfg.background_on    <= i_cfg_data[0];
                REG_FLIP_HORIZONTAL:  r_cfg.flip_horizontal  <= i_cfg_data[0];
                REG_BACKGROUND_COLOR: r_cfg.background_color <= i_cfg_data[RGB_W-1:0];
                REG_RIVER_COLOR:      r_cfg.river_color      <= i_cfg_data[RGB_W-1:0];
                REG_RIVER_COLUMN:     r_cfg.river_column     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // fill sequencer
    logic [LFSR_W-1:0] r_fill_shift;
    logic [LFSR_W-1:0] r_fill_index;
    logic              r_fill_done;
    logic [LFSR_W-1:0] n_fill_shift;
    logic              w_ram_we;
    logic [ENTRY_W-1:0] w_ram_wr_data;

    always_comb begin
        n_fill_shift  = {r_fill_shift[12] ~^ r_fill_shift[0], r_fill_shift[LFSR_W-1:1]};
        w_ram_we      = !r_fill_done && !r_fill_index[0];
        w_ram_wr_data = {((r_fill_shift & STAR_EN_MASK) == STAR_EN_MATCH),
                         ~r_fill_shift[8:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_shift <= '0;
            r_fill_index <= '0;
            r_fill_done  <= 1'b0;
        end else if (!r_fill_done) begin
            r_fill_shift <= n_fill_shift;
            r_fill_index <= r_fill_index + 17'd1;
            if (r_fill_index == LFSR_PERIOD - 17'd1) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    // stage enables
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;
    logic w_accept;

    assign w_en3    = !r_v3 || i_m_axis_tready;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign o_s_axis_tready = r_fill_done && w_en1;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // stage 1: capture pixel, read star RAM
    logic [7:0]         r1_x, r1_y;
    logic [1:0]         r1_phase;
    logic [ENTRY_W-1:0] w1_entry;

    sfb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (65536)
    ) u_star_ram (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_wr_addr (r_fill_index[STORE_AW:1]),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_en1),
        .i_rd_addr ({i_s_axis_tdata[15:8], i_s_axis_tdata[7:0]}),
        .o_rd_data (w1_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= w_accept;
        end
        if (w_en1) begin
            r1_x     <= i_s_axis_tdata[7:0];
            r1_y     <= i_s_axis_tdata[15:8];
            r1_phase <= i_s_axis_tdata[17:16];
        end
    end

    // stage 2: decide river, base and star visibility
    logic             w2_board_b, w2_river, w2_cand, w2_colour_ok, w2_shown;
    logic [1:0]       w2_blink;
    logic [RGB_W-1:0] w2_base;
    logic [RGB_W-1:0] r2_base;
    logic             r2_star;
    logic [5:0]       r2_colour;

    always_comb begin
        w2_board_b = (r_cfg.board_kind == BOARD_STAR_B);
        w2_river   = r_cfg.flip_horizontal ? (r1_x >= r_cfg.river_column)
                                           : (r1_x <  r_cfg.river_column);
        w2_blink   = w2_board_b ? r1_phase : BLINK_FIXED;
        w2_cand    = r_cfg.stars_on
                  && !(w2_board_b && (w2_blink == BLINK_LINES) && !r1_y[1])
                  && (r1_y[0] ^ r1_x[3]);
        case (w2_blink)
            BLINK_TOP: w2_colour_ok = w1_entry[5];
            BLINK_MID: w2_colour_ok = w1_entry[3];
            default:   w2_colour_ok = 1'b1;
        endcase
        w2_shown = w2_cand && w1_entry[6] && w2_colour_ok;
        if (r_cfg.board_kind == BOARD_RIVER) begin
            w2_base  = w2_river ? r_cfg.river_color : '0;
            w2_shown = 1'b0;
        end else begin
            w2_base  = (w2_board_b && r_cfg.background_on) ? r_cfg.background_color : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
        if (w_en2) begin
            r2_base   <= w2_base;
            r2_star   <= w2_shown;
            r2_colour <= w1_entry[5:0];
        end
    end

    // stage 3: gun levels and final select
    logic [RGB_W-1:0] r3_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
        if (w_en3) begin
            r3_rgb <= r2_star ? colour_to_rgb(r2_colour) : r2_base;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = r3_rgb;

    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fill_done |-> !o_s_axis_tready)
        else $error("input ready during star fill");

    a_fill_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_done |=> r_fill_done)
        else $error("fill done dropped");

    a_lfsr_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fill_done) |-> (r_fill_shift == '0))
        else $error("LFSR did not return to zero at end of fill");

    a_no_write_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_done |-> !w_ram_we)
        else $error("star RAM written after fill");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_en2) |=> (r_v2 && $stable(r2_base) && $stable(r2_star)))
        else $error("stage 2 changed while stalled");

endmodule
